/* rtl/half_duplex_serial_ring_buffers_macros.svh */
// ----------------------------------------------------------------------------
// half_duplex_serial_ring_buffers_macros
// assertion macros shared by the serial ring buffer rtl
// ----------------------------------------------------------------------------
`ifndef HALF_DUPLEX_SERIAL_RING_BUFFERS_MACROS_SVH
`define HALF_DUPLEX_SERIAL_RING_BUFFERS_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge out of reset
`define HDSRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define HDSRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define HDSRB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HDSRB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/hdsrb_pkg.sv */
// ----------------------------------------------------------------------------
// hdsrb_pkg
// types and constants of the half-duplex serial ring buffers
// ----------------------------------------------------------------------------
`default_nettype none

package hdsrb_pkg;

    // default ring depths
    localparam int TX_DEPTH_DEF = 32;
    localparam int RX_DEPTH_DEF = 32;

    // event codes on the input word
    typedef enum logic [2:0] {
        MODE_HOST_WR    = 3'd0,
        MODE_HOST_RD    = 3'd1,
        MODE_LINE_RX    = 3'd2,
        MODE_TX_READY   = 3'd3,
        MODE_SHIFT_DONE = 3'd4
    } t_mode;

    // line direction
    typedef enum logic [1:0] {
        LINE_RECEIVING = 2'd0,
        LINE_SENDING   = 2'd1,
        LINE_DRAINING  = 2'd2
    } t_line;

    // input word
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [7:0] out_data;
        logic       ok;
        logic [4:0] tx_count;
        logic [4:0] rx_count;
        logic [1:0] line_state;
        logic       tx_done;
    } t_out_word;

endpackage

`default_nettype wire

/* rtl/half_duplex_serial_ring_buffers.sv */
// ----------------------------------------------------------------------------
// half_duplex_serial_ring_buffers
// transmit and receive ring buffers for a half-duplex serial line
// ----------------------------------------------------------------------------
//
//   channel   valid         stall         word
//   -------   -----------   -----------   ------------
//   events    i_in_valid    o_in_stall    i_in_word
//   results   o_out_valid   i_out_stall   o_out_word
//
// one event word is taken per cycle while the event side is not stalled; pointer
// update and registered ram read happen at the accepting edge into the pending
// slot, and the ram read data lands in the output register when that slot moves.
// reset clears pointers, sets the line direction to receiving and sets the done
// flag; ring contents are not cleared and need no sweep.
// a stalled output register holds its word; the event side stalls only when
// the pending slot is full and the output register is full and stalled.
//
`default_nettype none

`include "half_duplex_serial_ring_buffers_macros.svh"

module half_duplex_serial_ring_buffers #(
    parameter int TX_DEPTH = hdsrb_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = hdsrb_pkg::RX_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire hdsrb_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output hdsrb_pkg::t_out_word      o_out_word
);

    import hdsrb_pkg::*;

    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_AW = $clog2(RX_DEPTH);

    localparam logic [TX_AW-1:0] TX_LAST   = TX_AW'(TX_DEPTH - 1);
    localparam logic [RX_AW-1:0] RX_LAST   = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW:0]   TX_SPAN   = (TX_AW + 1)'(TX_DEPTH);
    localparam logic [RX_AW:0]   RX_SPAN   = (RX_AW + 1)'(RX_DEPTH);
    // highest fill level at which a host write still goes in
    localparam logic [TX_AW:0]   TX_WR_MAX = (TX_AW + 1)'(TX_DEPTH - 2);

    // architectural state
    logic [TX_AW-1:0] r_tx_head, n_tx_head;
    logic [TX_AW-1:0] r_tx_tail, n_tx_tail;
    logic [RX_AW-1:0] r_rx_head, n_rx_head;
    logic [RX_AW-1:0] r_rx_tail, n_rx_tail;
    t_line            r_line,    n_line;
    logic             r_done,    n_done;

    // pending slot: item accepted, waiting for ram data
    logic r_p_valid, n_p_valid;
    logic r_p_ok,    n_p_ok;
    logic r_p_rd_tx, n_p_rd_tx;
    logic r_p_rd_rx, n_p_rd_rx;

    // output register
    logic      r_o_valid, n_o_valid;
    t_out_word r_o_word,  n_o_word;

    // ram ports
    logic       tx_we, tx_re, rx_we, rx_re;
    logic [7:0] tx_rdata, rx_rdata;

    logic           in_acc, out_free, p_move;
    logic [TX_AW:0] tx_cnt;
    logic [RX_AW:0] rx_cnt;
    logic [TX_AW-1:0] tx_tail_inc;
    logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
    logic [TX_AW-1:0] tx_head_inc;

    // handshake
    assign out_free   = !r_o_valid || !i_out_stall;
    assign p_move     = r_p_valid && out_free;
    assign o_in_stall = r_p_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // fill levels of both rings
    always_comb begin
        if (r_tx_head >= r_tx_tail) begin
            tx_cnt = {1'b0, r_tx_head} - {1'b0, r_tx_tail};
        end else begin
            tx_cnt = {1'b0, r_tx_head} + TX_SPAN - {1'b0, r_tx_tail};
        end
        if (r_rx_head >= r_rx_tail) begin
            rx_cnt = {1'b0, r_rx_head} - {1'b0, r_rx_tail};
        end else begin
            rx_cnt = {1'b0, r_rx_head} + RX_SPAN - {1'b0, r_rx_tail};
        end
    end

    // wrapped pointer increments
    assign tx_head_inc = (r_tx_head == TX_LAST) ? '0 : r_tx_head + 1'b1;
    assign tx_tail_inc = (r_tx_tail == TX_LAST) ? '0 : r_tx_tail + 1'b1;
    assign rx_head_inc = (r_rx_head == RX_LAST) ? '0 : r_rx_head + 1'b1;
    assign rx_tail_inc = (r_rx_tail == RX_LAST) ? '0 : r_rx_tail + 1'b1;

    // event decode and state update
    always_comb begin
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_line    = r_line;
        n_done    = r_done;
        n_p_ok    = r_p_ok;
        n_p_rd_tx = r_p_rd_tx;
        n_p_rd_rx = r_p_rd_rx;
        tx_we     = 1'b0;
        tx_re     = 1'b0;
        rx_we     = 1'b0;
        rx_re     = 1'b0;
        if (in_acc) begin
            n_p_ok    = 1'b0;
            n_p_rd_tx = 1'b0;
            n_p_rd_rx = 1'b0;
            unique case (t_mode'(i_in_word.mode))
                MODE_HOST_WR: begin
                    if (tx_cnt <= TX_WR_MAX) begin
                        tx_we     = 1'b1;
                        n_tx_head = tx_head_inc;
                        n_done    = 1'b0;
                        n_line    = LINE_SENDING;
                        n_p_ok    = 1'b1;
                    end
                end
                MODE_HOST_RD: begin
                    if (r_rx_head != r_rx_tail) begin
                        rx_re     = 1'b1;
                        n_rx_tail = rx_tail_inc;
                        n_p_rd_rx = 1'b1;
                        n_p_ok    = 1'b1;
                    end
                end
                MODE_LINE_RX: begin
                    if (r_line == LINE_RECEIVING) begin
                        rx_we     = 1'b1;
                        n_rx_head = rx_head_inc;
                        n_p_ok    = 1'b1;
                    end
                end
                MODE_TX_READY: begin
                    if (r_line == LINE_SENDING && r_tx_head != r_tx_tail) begin
                        tx_re     = 1'b1;
                        n_tx_tail = tx_tail_inc;
                        n_p_rd_tx = 1'b1;
                        n_p_ok    = 1'b1;
                        if (tx_tail_inc == r_tx_head) begin
                            n_line = LINE_DRAINING;
                        end
                    end
                end
                MODE_SHIFT_DONE: begin
                    if (r_line == LINE_DRAINING) begin
                        n_line = LINE_RECEIVING;
                        n_done = 1'b1;
                        n_p_ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // pending slot and output register control
    always_comb begin
        n_p_valid = r_p_valid;
        if (in_acc) begin
            n_p_valid = 1'b1;
        end else if (p_move) begin
            n_p_valid = 1'b0;
        end
        n_o_valid = r_o_valid;
        if (p_move) begin
            n_o_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    // result word, built from ram data and the state the item left behind
    always_comb begin
        n_o_word = r_o_word;
        if (p_move) begin
            n_o_word.out_data   = r_p_rd_tx ? tx_rdata : (r_p_rd_rx ? rx_rdata : 8'd0);
            n_o_word.ok         = r_p_ok;
            n_o_word.tx_count   = 5'(tx_cnt);
            n_o_word.rx_count   = 5'(rx_cnt);
            n_o_word.line_state = r_line;
            n_o_word.tx_done    = r_done;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_line    <= LINE_RECEIVING;
            r_done    <= 1'b1;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_line    <= n_line;
            r_done    <= n_done;
            r_p_valid <= n_p_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p_ok    <= n_p_ok;
        r_p_rd_tx <= n_p_rd_tx;
        r_p_rd_rx <= n_p_rd_rx;
        r_o_word  <= n_o_word;
    end

    // transmit ring
    hdsrb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (i_in_word.data),
        .i_re    (tx_re),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_rdata)
    );

    // receive ring
    hdsrb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (i_in_word.data),
        .i_re    (rx_re),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

    // line direction against transmit ring fill
    `HDSRB_ASSERT_NOW(a_rx_tx_empty, i_clk, i_rst_n, r_line == LINE_RECEIVING, r_tx_head == r_tx_tail)
    `HDSRB_ASSERT_NOW(a_send_nonempty, i_clk, i_rst_n, r_line == LINE_SENDING, r_tx_head != r_tx_tail)
    `HDSRB_ASSERT_NOW(a_done_rx, i_clk, i_rst_n, r_done, r_line == LINE_RECEIVING)
    // a pending item never loses its slot while the output is blocked
    `HDSRB_ASSERT_NXT(a_pend_hold, i_clk, i_rst_n, r_p_valid && r_o_valid && i_out_stall, r_p_valid && r_o_valid)

endmodule

`default_nettype wire

/* rtl/hdsrb_ram.sv */
// ----------------------------------------------------------------------------
// hdsrb_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hdsrb_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
